// File: design/fpsa_pkg.sv
package fpsa_pkg;

	localparam int MaxSegments = 16;
	localparam int IdxW = $clog2(MaxSegments);
	localparam int CntW = $clog2(MaxSegments + 1);
	localparam logic [15:0] DefaultMemSize = 16'd1024;

	localparam logic RegFitPolicy = 1'b0;
	localparam logic RegMemSize = 1'b1;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_NEXT = 2'd1,
		POL_BEST = 2'd2,
		POL_WORST = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_NO_OWNER = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SPLIT_SHIFT,
		S_SPLIT_FIN,
		S_GRANT,
		S_REL,
		S_MERGE,
		S_MERGE_SHIFT,
		S_MERGE_FIN,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic init;
		logic scan_clr;
		logic scan_step;
		logic shift_up;
		logic split_fin;
		logic grant;
		logic rel_clr;
		logic rel_step;
		logic merge_add;
		logic merge_next;
		logic shift_dn;
		logic merge_fin;
		logic out_load;
		logic [1:0] out_status;
		logic out_alloc;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic found;
		logic split_ok;
		logic shift_end;
		logic rel_end;
		logic merge_end;
		logic dn_end;
		logic pair_free;
		logic any_rel;
	} dp_sts_t;

endpackage

// File: design/fpsa_datapath.sv
module fpsa_datapath import fpsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic load,
	input  logic [15:0] request_size,
	input  logic [15:0] owner_id,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic is_zero,
	output logic out_valid,
	output logic [1:0] status,
	output logic [15:0] granted_start,
	output logic [15:0] granted_length
);

	logic [15:0] start_q [MaxSegments];
	logic [15:0] len_q [MaxSegments];
	logic [15:0] owner_q [MaxSegments];
	logic [MaxSegments-1:0] free_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] rove_q;
	logic rove_vld_q;
	logic [1:0] policy_q;
	logic [15:0] msize_q;
	logic [15:0] size_q, owner_id_q;
	logic [CntW-1:0] ptr_q;
	logic [CntW-1:0] step_q;
	logic [IdxW-1:0] pick_q;
	logic found_q;
	logic [15:0] total_q;
	logic any_q;
	logic [CntW-1:0] k_q;

	logic [IdxW-1:0] cur, nxt_i;
	logic [CntW-1:0] first;
	logic fit_cur, better;
	logic [16:0] size_p1;

	assign is_zero = (request_size == 16'd0);
	assign first = (rove_vld_q && ({1'b0, rove_q} + 1'b1 < count_q)) ?
		CntW'({1'b0, rove_q} + 1'b1) : '0;
	assign cur = ptr_q[IdxW-1:0];
	assign nxt_i = IdxW'(cur + 1'b1);
	assign fit_cur = (ptr_q < count_q) && free_q[cur] && (len_q[cur] >= size_q);
	always_comb begin
		case (policy_q)
			POL_BEST:  better = len_q[cur] < len_q[pick_q];
			POL_WORST: better = len_q[cur] > len_q[pick_q];
			default:   better = 1'b0;
		endcase
	end
	assign size_p1 = {1'b0, size_q} + 17'd1;

	assign sts.scan_end = (step_q == count_q) ||
		(found_q && (policy_q == POL_FIRST || policy_q == POL_NEXT));
	assign sts.found = found_q;
	assign sts.split_ok = ({1'b0, len_q[pick_q]} > size_p1) && (count_q < CntW'(MaxSegments));
	assign sts.shift_end = (k_q <= CntW'(pick_q) + 1'b1);
	assign sts.rel_end = (ptr_q == count_q);
	assign sts.merge_end = (ptr_q + 1'b1 >= count_q);
	assign sts.dn_end = (k_q + 1'b1 >= count_q);
	assign sts.pair_free = free_q[cur] && free_q[nxt_i];
	assign sts.any_rel = any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= MaxSegments'(1);
			count_q <= CntW'(1);
			rove_q <= '0;
			rove_vld_q <= 1'b0;
			policy_q <= POL_FIRST;
			msize_q <= DefaultMemSize;
			start_q[0] <= '0;
			len_q[0] <= DefaultMemSize;
			out_valid <= 1'b0;
		end else begin
			out_valid <= cmd.out_load;
			if (cfg_we && cfg_idx == RegFitPolicy)
				policy_q <= cfg_data[1:0];
			if (cfg_we && cfg_idx == RegMemSize) begin
				msize_q <= cfg_data;
				free_q <= MaxSegments'(1);
				count_q <= CntW'(1);
				rove_q <= '0;
				rove_vld_q <= 1'b0;
				start_q[0] <= '0;
				len_q[0] <= cfg_data;
			end
			if (cmd.init) begin
				free_q <= MaxSegments'(1);
				count_q <= CntW'(1);
				start_q[0] <= '0;
				len_q[0] <= msize_q;
			end
			if (cmd.scan_clr) begin
				ptr_q <= (policy_q == POL_NEXT) ? first : '0;
				step_q <= '0;
				found_q <= 1'b0;
				total_q <= '0;
				any_q <= 1'b0;
				k_q <= count_q;
			end
			if (cmd.scan_step) begin
				if (fit_cur && (!found_q || better)) begin
					found_q <= 1'b1;
					pick_q <= cur;
				end
				step_q <= step_q + 1'b1;
				ptr_q <= (ptr_q + 1'b1 >= count_q) ? '0 : ptr_q + 1'b1;
			end
			if (cmd.shift_up) begin
				start_q[k_q[IdxW-1:0]] <= start_q[IdxW'(k_q - 1'b1)];
				len_q[k_q[IdxW-1:0]] <= len_q[IdxW'(k_q - 1'b1)];
				owner_q[k_q[IdxW-1:0]] <= owner_q[IdxW'(k_q - 1'b1)];
				free_q[k_q[IdxW-1:0]] <= free_q[IdxW'(k_q - 1'b1)];
				k_q <= k_q - 1'b1;
			end
			if (cmd.split_fin) begin
				start_q[IdxW'(pick_q + 1'b1)] <= start_q[pick_q] + size_q;
				len_q[IdxW'(pick_q + 1'b1)] <= len_q[pick_q] - size_q;
				owner_q[IdxW'(pick_q + 1'b1)] <= '0;
				free_q[IdxW'(pick_q + 1'b1)] <= 1'b1;
				len_q[pick_q] <= size_q;
				count_q <= count_q + 1'b1;
			end
			if (cmd.grant) begin
				free_q[pick_q] <= 1'b0;
				owner_q[pick_q] <= owner_id_q;
				rove_q <= pick_q;
				rove_vld_q <= 1'b1;
			end
			if (cmd.rel_clr)
				ptr_q <= '0;
			if (cmd.rel_step) begin
				// skip the slot past the table end
				if (!sts.rel_end && !free_q[cur] && owner_q[cur] == owner_id_q) begin
					free_q[cur] <= 1'b1;
					total_q <= total_q + len_q[cur];
					any_q <= 1'b1;
				end
				ptr_q <= sts.rel_end ? '0 : ptr_q + 1'b1;
			end
			if (cmd.merge_add) begin
				len_q[cur] <= len_q[cur] + len_q[nxt_i];
				k_q <= CntW'(nxt_i);
				if (rove_q > cur)
					rove_q <= rove_q - 1'b1;
			end
			if (cmd.merge_next)
				ptr_q <= ptr_q + 1'b1;
			if (cmd.shift_dn) begin
				start_q[k_q[IdxW-1:0]] <= start_q[IdxW'(k_q + 1'b1)];
				len_q[k_q[IdxW-1:0]] <= len_q[IdxW'(k_q + 1'b1)];
				owner_q[k_q[IdxW-1:0]] <= owner_q[IdxW'(k_q + 1'b1)];
				free_q[k_q[IdxW-1:0]] <= free_q[IdxW'(k_q + 1'b1)];
				k_q <= k_q + 1'b1;
			end
			if (cmd.merge_fin)
				count_q <= count_q - 1'b1;
			if (cmd.out_load) begin
				status <= cmd.out_status;
				if (cmd.out_status != ST_OK) begin
					granted_start <= '0;
					granted_length <= '0;
				end else if (cmd.out_alloc) begin
					granted_start <= start_q[pick_q];
					granted_length <= len_q[pick_q];
				end else begin
					granted_start <= '0;
					granted_length <= total_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			size_q <= request_size;
			owner_id_q <= owner_id;
		end
	end

endmodule

// File: design/fpsa_ctrl.sv
module fpsa_ctrl import fpsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic kind,
	input  logic is_zero,
	input  dp_sts_t sts,
	output logic busy,
	output logic load,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic kind_q, zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				kind_q <= kind;
				zero_q <= is_zero;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign load = start && !busy;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (load) begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (kind_q) begin
					cmd.rel_clr = 1'b1;
					state_d = S_REL;
				end else if (zero_q) begin
					cmd.out_load = 1'b1;
					cmd.out_status = ST_ZERO;
					state_d = S_DONE;
				end else if (sts.scan_end) begin
					if (!sts.found) begin
						cmd.out_load = 1'b1;
						cmd.out_status = ST_NO_FIT;
						state_d = S_DONE;
					end else if (sts.split_ok) begin
						state_d = S_SPLIT_SHIFT;
					end else begin
						state_d = S_GRANT;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SPLIT_SHIFT: begin
				if (sts.shift_end) state_d = S_SPLIT_FIN;
				else cmd.shift_up = 1'b1;
			end
			S_SPLIT_FIN: begin
				cmd.split_fin = 1'b1;
				state_d = S_GRANT;
			end
			S_GRANT: begin
				cmd.grant = 1'b1;
				cmd.out_load = 1'b1;
				cmd.out_status = ST_OK;
				cmd.out_alloc = 1'b1;
				state_d = S_DONE;
			end
			S_REL: begin
				cmd.rel_step = 1'b1;
				if (sts.rel_end) state_d = S_MERGE;
			end
			S_MERGE: begin
				if (sts.merge_end) begin
					cmd.out_load = 1'b1;
					cmd.out_status = sts.any_rel ? ST_OK : ST_NO_OWNER;
					state_d = S_DONE;
				end else if (sts.pair_free) begin
					cmd.merge_add = 1'b1;
					state_d = S_MERGE_SHIFT;
				end else begin
					cmd.merge_next = 1'b1;
				end
			end
			S_MERGE_SHIFT: begin
				if (sts.dn_end) state_d = S_MERGE_FIN;
				else cmd.shift_dn = 1'b1;
			end
			S_MERGE_FIN: begin
				cmd.merge_fin = 1'b1;
				state_d = S_MERGE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: design/fit_policy_segment_allocator.sv
// Segment allocator, 16-entry table. Raise start while busy is low; the single result word
// appears on status/granted_* for exactly one cycle with done high and cannot be stalled.
// A zero-size allocation ends without a scan; else the fit scan or owner release walks
// the table entry by entry, and a split or each merge during a free shifts the table one
// entry at a time. Writing the size register reinitialises the table at once.
module fit_policy_segment_allocator import fpsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic start,
	output logic busy,
	input  logic kind,
	input  logic [15:0] request_size,
	input  logic [15:0] owner_id,
	output logic done,
	output logic [1:0] status,
	output logic [15:0] granted_start,
	output logic [15:0] granted_length
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic load, is_zero;

	fpsa_ctrl u_ctrl (
		.clk, .arst_n, .start, .kind, .is_zero, .sts, .busy, .load, .cmd
	);

	fpsa_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .load, .request_size,
		.owner_id, .cmd, .sts, .is_zero, .out_valid(done), .status,
		.granted_start, .granted_length
	);

endmodule
